// File: rtl/nrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrm_pkg
// Shared types and constants of the NaN-aware running median filter.
// ----------------------------------------------------------------------------
package nrm_pkg;

    // Range sample width; the all-ones value stands for +inf
    localparam int RANGE_BITS = 16;
    // Sort key: valid flag over the range value, invalid keys are all zero
    localparam int KEY_W      = RANGE_BITS + 1;
    // Default window length
    localparam int WINDOW_DEF = 5;

    // Item modes
    localparam logic MODE_PUSH  = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    typedef logic [KEY_W-1:0] nrm_key_t;

    typedef struct packed {
        logic                  mode;
        logic [RANGE_BITS-1:0] range_mm;
        logic                  range_invalid;
    } nrm_in_t;

    typedef struct packed {
        logic [RANGE_BITS-1:0] median_mm;
        logic                  centre_invalid;
        logic [RANGE_BITS-1:0] centre_mm;
        logic [RANGE_BITS-1:0] raised_mm;
    } nrm_out_t;

    // Flags of the shared key comparator
    typedef struct packed {
        logic lt;
        logic eq;
        logic gt;
    } nrm_cmp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_RD_OLD,
        ST_FIND,
        ST_DOWN,
        ST_UP,
        ST_PLACE,
        ST_MED,
        ST_CENTRE
    } nrm_state_t;

endpackage

// File: rtl/nrm_key_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrm_key_cmp
// Shared magnitude comparator on sort keys, used by the search, shift and centre steps.
// ----------------------------------------------------------------------------
module nrm_key_cmp (
    input  nrm_pkg::nrm_key_t cmp_a,
    input  nrm_pkg::nrm_key_t cmp_b,
    output nrm_pkg::nrm_cmp_t cmp_flags
);

    // Compare a against b as unsigned keys
    always_comb begin
        cmp_flags.lt = (cmp_a < cmp_b);
        cmp_flags.eq = (cmp_a == cmp_b);
        cmp_flags.gt = !cmp_flags.lt && !cmp_flags.eq;
    end

endmodule

// File: rtl/nan_aware_running_median.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nan_aware_running_median
// Sliding-window median of range samples; invalid samples are kept in the
// window but excluded from the median. One result per push, none per clear.
// ----------------------------------------------------------------------------
// A push runs the search and shift of the sorted list one entry per cycle
//   through the shared comparator, plus any wait for an unaccepted earlier
//   result. A clear writes its range into every window slot as a valid
//   sample and gives no result.
// Throughput: one item at a time; s_ready is high only while idle.
// Reset (aresetn low, synchronous): window holds valid zeros, write slot is
//   WINDOW-1, valid count is WINDOW, held median is zero, no result pending.
// ----------------------------------------------------------------------------
module nan_aware_running_median #(
    parameter int WINDOW = nrm_pkg::WINDOW_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  nrm_pkg::nrm_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output nrm_pkg::nrm_out_t m_data
);

    localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int LAG   = WINDOW / 2;
    localparam int RB    = nrm_pkg::RANGE_BITS;

    localparam logic [PTR_W-1:0] LAST_POS  = PTR_W'(WINDOW - 1);
    localparam logic [PTR_W:0]   CTR_OFS   = (PTR_W + 1)'(WINDOW - LAG);
    localparam logic [PTR_W:0]   WIN_EXT   = (PTR_W + 1)'(WINDOW);
    localparam logic [CNT_W-1:0] WIN_CNT   = CNT_W'(WINDOW);
    localparam logic [RB-1:0]    RANGE_INF = '1;

    // Registers
    nrm_pkg::nrm_state_t state_reg, state_next;
    logic [PTR_W-1:0]    cnt_reg, cnt_next;
    logic [PTR_W-1:0]    at_reg, at_next;
    logic [PTR_W-1:0]    wp_reg, wp_next;
    logic [CNT_W-1:0]    vc_reg, vc_next;
    logic [RB-1:0]       held_reg, held_next;
    logic [RB-1:0]       fill_reg, fill_next;
    logic                moved_reg, moved_next;
    nrm_pkg::nrm_key_t   old_key_reg, old_key_next;
    nrm_pkg::nrm_key_t   new_key_reg, new_key_next;
    logic                m_valid_reg, m_valid_next;
    nrm_pkg::nrm_out_t   m_data_reg, m_data_next;

    nrm_pkg::nrm_key_t   ring_reg   [WINDOW];
    nrm_pkg::nrm_key_t   sorted_reg [WINDOW];

    // Array access
    logic                ring_we, sorted_we;
    logic [PTR_W-1:0]    ring_wa, sorted_wa, ring_ra, sorted_ra;
    nrm_pkg::nrm_key_t   ring_wd, sorted_wd, ring_rd, sorted_rd;

    // Shared comparator
    nrm_pkg::nrm_key_t   cmp_a, cmp_b;
    nrm_pkg::nrm_cmp_t   cmp_flags;

    // Derived values
    logic                in_acc;
    logic                out_free;
    logic [PTR_W:0]      ctr_sum;
    logic [PTR_W-1:0]    centre_pos;
    logic [CNT_W-1:0]    vc_m1;
    logic [CNT_W-1:0]    idx_full;
    logic [PTR_W-1:0]    med_idx;
    logic                centre_inv;
    logic [RB-1:0]       centre_val;
    logic                at_first, at_last;

    assign in_acc   = s_valid && (state_reg == nrm_pkg::ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign at_first = (at_reg == '0);
    assign at_last  = (at_reg == LAST_POS);

    // Centre slot lags the write slot by WINDOW/2
    always_comb begin
        ctr_sum = {1'b0, wp_reg} + CTR_OFS;
        if (ctr_sum >= WIN_EXT) begin
            ctr_sum = ctr_sum - WIN_EXT;
        end
        centre_pos = ctr_sum[PTR_W-1:0];
    end

    // Median index over the valid entries, lower middle for even counts
    assign vc_m1    = vc_reg - CNT_W'(1);
    assign idx_full = (vc_m1 >> 1) + (WIN_CNT - vc_reg);
    assign med_idx  = idx_full[PTR_W-1:0];

    // Select read addresses
    always_comb begin
        case (state_reg)
            nrm_pkg::ST_DOWN:   sorted_ra = at_first ? at_reg : at_reg - PTR_W'(1);
            nrm_pkg::ST_UP:     sorted_ra = at_last ? at_reg : at_reg + PTR_W'(1);
            nrm_pkg::ST_MED:    sorted_ra = med_idx;
            default:            sorted_ra = cnt_reg;
        endcase
        ring_ra = (state_reg == nrm_pkg::ST_CENTRE) ? centre_pos : wp_reg;
    end

    assign sorted_rd = sorted_reg[sorted_ra];
    assign ring_rd   = ring_reg[ring_ra];

    assign centre_inv = !ring_rd[RB];
    assign centre_val = centre_inv ? '0 : ring_rd[RB-1:0];

    // Steer comparator operands
    always_comb begin
        cmp_a = sorted_rd;
        cmp_b = new_key_reg;
        case (state_reg)
            nrm_pkg::ST_FIND: begin
                cmp_b = old_key_reg;
            end
            nrm_pkg::ST_CENTRE: begin
                cmp_a = {1'b1, held_reg};
                cmp_b = {1'b1, centre_val};
            end
            default: begin
                cmp_b = new_key_reg;
            end
        endcase
    end

    nrm_key_cmp u_cmp (
        .cmp_a     (cmp_a),
        .cmp_b     (cmp_b),
        .cmp_flags (cmp_flags)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            nrm_pkg::ST_IDLE: begin
                if (in_acc) begin
                    state_next = (s_data.mode == nrm_pkg::MODE_CLEAR) ?
                                 nrm_pkg::ST_FILL : nrm_pkg::ST_RD_OLD;
                end
            end
            nrm_pkg::ST_FILL: begin
                if (cnt_reg == LAST_POS) begin
                    state_next = nrm_pkg::ST_IDLE;
                end
            end
            nrm_pkg::ST_RD_OLD: begin
                state_next = nrm_pkg::ST_FIND;
            end
            nrm_pkg::ST_FIND: begin
                if (cmp_flags.eq || cnt_reg == LAST_POS) begin
                    state_next = nrm_pkg::ST_DOWN;
                end
            end
            nrm_pkg::ST_DOWN: begin
                if (at_first || !cmp_flags.gt) begin
                    state_next = moved_reg ? nrm_pkg::ST_PLACE : nrm_pkg::ST_UP;
                end
            end
            nrm_pkg::ST_UP: begin
                if (moved_reg || at_last || !cmp_flags.lt) begin
                    state_next = nrm_pkg::ST_PLACE;
                end
            end
            nrm_pkg::ST_PLACE: begin
                state_next = (vc_reg != '0) ? nrm_pkg::ST_MED : nrm_pkg::ST_CENTRE;
            end
            nrm_pkg::ST_MED: begin
                state_next = nrm_pkg::ST_CENTRE;
            end
            nrm_pkg::ST_CENTRE: begin
                if (out_free) begin
                    state_next = nrm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = nrm_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and array writes
    always_comb begin
        cnt_next     = cnt_reg;
        at_next      = at_reg;
        wp_next      = wp_reg;
        vc_next      = vc_reg;
        held_next    = held_reg;
        fill_next    = fill_reg;
        moved_next   = moved_reg;
        old_key_next = old_key_reg;
        new_key_next = new_key_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        ring_we      = 1'b0;
        ring_wa      = wp_reg;
        ring_wd      = new_key_reg;
        sorted_we    = 1'b0;
        sorted_wa    = at_reg;
        sorted_wd    = sorted_rd;

        // Drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            nrm_pkg::ST_IDLE: begin
                if (in_acc) begin
                    cnt_next     = '0;
                    fill_next    = s_data.range_mm;
                    new_key_next = s_data.range_invalid ? '0 : {1'b1, s_data.range_mm};
                    if (s_data.mode == nrm_pkg::MODE_PUSH) begin
                        wp_next = (wp_reg == LAST_POS) ? '0 : wp_reg + PTR_W'(1);
                    end
                end
            end
            nrm_pkg::ST_FILL: begin
                ring_we   = 1'b1;
                ring_wa   = cnt_reg;
                ring_wd   = {1'b1, fill_reg};
                sorted_we = 1'b1;
                sorted_wa = cnt_reg;
                sorted_wd = {1'b1, fill_reg};
                cnt_next  = cnt_reg + PTR_W'(1);
                if (cnt_reg == LAST_POS) begin
                    cnt_next  = '0;
                    wp_next   = LAST_POS;
                    vc_next   = WIN_CNT;
                    held_next = fill_reg;
                end
            end
            nrm_pkg::ST_RD_OLD: begin
                // Swap the new key into the ring and fix the valid count
                old_key_next = ring_rd;
                ring_we      = 1'b1;
                vc_next      = vc_reg - CNT_W'(ring_rd[RB]) + CNT_W'(new_key_reg[RB]);
                cnt_next     = '0;
            end
            nrm_pkg::ST_FIND: begin
                if (cmp_flags.eq || cnt_reg == LAST_POS) begin
                    at_next    = cnt_reg;
                    moved_next = 1'b0;
                end else begin
                    cnt_next = cnt_reg + PTR_W'(1);
                end
            end
            nrm_pkg::ST_DOWN: begin
                // Shift larger entries up into the hole
                if (!at_first && cmp_flags.gt) begin
                    sorted_we  = 1'b1;
                    at_next    = at_reg - PTR_W'(1);
                    moved_next = 1'b1;
                end
            end
            nrm_pkg::ST_UP: begin
                // Shift smaller entries down into the hole
                if (!moved_reg && !at_last && cmp_flags.lt) begin
                    sorted_we = 1'b1;
                    at_next   = at_reg + PTR_W'(1);
                end
            end
            nrm_pkg::ST_PLACE: begin
                sorted_we = 1'b1;
                sorted_wd = new_key_reg;
            end
            nrm_pkg::ST_MED: begin
                held_next = sorted_rd[RB-1:0];
            end
            nrm_pkg::ST_CENTRE: begin
                if (out_free) begin
                    m_valid_next               = 1'b1;
                    m_data_next.median_mm      = held_reg;
                    m_data_next.centre_invalid = centre_inv;
                    m_data_next.centre_mm      = centre_val;
                    if (centre_inv || centre_val == RANGE_INF) begin
                        m_data_next.raised_mm = centre_val;
                    end else begin
                        m_data_next.raised_mm = cmp_flags.lt ? centre_val : held_reg;
                    end
                end
            end
            default: begin
                cnt_next = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= nrm_pkg::ST_IDLE;
            cnt_reg     <= '0;
            at_reg      <= '0;
            wp_reg      <= LAST_POS;
            vc_reg      <= WIN_CNT;
            held_reg    <= '0;
            moved_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            at_reg      <= at_next;
            wp_reg      <= wp_next;
            vc_reg      <= vc_next;
            held_reg    <= held_next;
            moved_reg   <= moved_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        fill_reg    <= fill_next;
        old_key_reg <= old_key_next;
        new_key_reg <= new_key_next;
        m_data_reg  <= m_data_next;
    end

    // Window ring and sorted copy, reset to valid zeros
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW; i++) begin
                ring_reg[i]   <= {1'b1, {RB{1'b0}}};
                sorted_reg[i] <= {1'b1, {RB{1'b0}}};
            end
        end else begin
            if (ring_we) begin
                ring_reg[ring_wa] <= ring_wd;
            end
            if (sorted_we) begin
                sorted_reg[sorted_wa] <= sorted_wd;
            end
        end
    end

    assign s_ready = (state_reg == nrm_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
